// ----- src/cih_pkg.sv -----
// ----------------------------------------------------------------------------
// cih_pkg
// Types and constants shared by the cursor inactivity hider.
// ----------------------------------------------------------------------------
`default_nettype none

package cih_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned TOUT_W  = 32;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_FALLBACK  = 2'd2;

    // Configuration reset values
    localparam logic [POS_W-1:0]   THRESHOLD_RST = 16'd8;
    localparam logic [TOUT_W-1:0]  TIMEOUT_RST   = 32'd2000000;
    localparam logic [FRAME_W-1:0] FALLBACK_RST  = 16'd120;

    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              initial_deflection;
        logic              is_pressed;
        logic              clock_valid;
        logic [TIME_W-1:0] time_usec;
    } t_sample;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic             show_cursor;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0]   motion_threshold;
        logic [TOUT_W-1:0]  timeout_usec;
        logic [FRAME_W-1:0] fallback_frames;
    } t_cfg;

    // Stage handshake between the sample register and the result register
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ----- src/cih_sample_if.sv -----
// ----------------------------------------------------------------------------
// cih_sample_if
// Valid/ready channel carrying one pointer sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface cih_sample_if;
    logic             valid;
    logic             ready;
    cih_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/cih_result_if.sv -----
// ----------------------------------------------------------------------------
// cih_result_if
// Valid/ready channel carrying one cursor result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cih_result_if;
    logic             valid;
    logic             ready;
    cih_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/cih_in_reg.sv -----
// ----------------------------------------------------------------------------
// cih_in_reg
// Sample register: holds one accepted sample until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cih_in_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire cih_pkg::t_sample i_data,
    output logic                  o_ready,
    input  wire logic             i_advance,
    output logic                  o_valid,
    output cih_pkg::t_sample      o_data
);
    import cih_pkg::*;

    logic    r_valid;
    t_sample r_data;

    // Take a new sample when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/cih_update.sv -----
// ----------------------------------------------------------------------------
// cih_update
// Activity detection and hide timer: state registers and their next values.
// ----------------------------------------------------------------------------
`default_nettype none

module cih_update (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cih_pkg::t_stage_ctl i_ctl,
    input  wire cih_pkg::t_sample   i_sample,
    input  wire cih_pkg::t_cfg      i_cfg,
    output cih_pkg::t_result        o_result
);
    import cih_pkg::*;

    logic                r_seen_first, n_seen_first;
    logic [POS_W-1:0]    r_anchor_x, n_anchor_x;
    logic [POS_W-1:0]    r_anchor_y, n_anchor_y;
    logic                r_prev_pressed, n_prev_pressed;
    logic [TIME_W-1:0]   r_stamp, n_stamp;
    logic [FRAME_W-1:0]  r_idle_frames, n_idle_frames;
    logic                r_clock_mode, n_clock_mode;
    logic                r_shown, n_shown;

    logic [POS_W-1:0]    dx;
    logic [POS_W-1:0]    dy;
    logic                moved;
    logic                activity;
    logic [TIME_W:0]     elapsed;
    logic                clock_back;
    logic                timed_out;
    logic [FRAME_W-1:0]  frames_inc;

    // Distance from the anchor on each axis
    assign dx = (i_sample.pos_x >= r_anchor_x) ? i_sample.pos_x - r_anchor_x
                                               : r_anchor_x - i_sample.pos_x;
    assign dy = (i_sample.pos_y >= r_anchor_y) ? i_sample.pos_y - r_anchor_y
                                               : r_anchor_y - i_sample.pos_y;

    assign moved = (dx >= i_cfg.motion_threshold) || (dy >= i_cfg.motion_threshold) ||
                   (i_sample.is_pressed && !r_prev_pressed);

    assign activity = r_seen_first ? moved
                                   : (i_sample.initial_deflection || i_sample.is_pressed);

    // Elapsed time; the borrow flags a clock that ran backwards
    assign elapsed    = {1'b0, i_sample.time_usec} - {1'b0, r_stamp};
    assign clock_back = elapsed[TIME_W];
    // Any upper bit set means the elapsed time is beyond every timeout
    assign timed_out  = (elapsed[TIME_W-1:TOUT_W] != '0) ||
                        (elapsed[TOUT_W-1:0] >= i_cfg.timeout_usec);

    // Saturating idle frame count
    assign frames_inc = (r_idle_frames == FRAME_MAX) ? r_idle_frames
                                                     : r_idle_frames + 1'b1;

    always_comb begin
        n_seen_first   = 1'b1;
        n_anchor_x     = r_anchor_x;
        n_anchor_y     = r_anchor_y;
        n_prev_pressed = i_sample.is_pressed;
        n_stamp        = r_stamp;
        n_idle_frames  = r_idle_frames;
        n_clock_mode   = r_clock_mode;
        n_shown        = r_shown;

        if (!r_seen_first || activity) begin
            n_anchor_x = i_sample.pos_x;
            n_anchor_y = i_sample.pos_y;
        end

        priority if (activity) begin
            n_stamp       = i_sample.time_usec;
            n_idle_frames = '0;
            n_clock_mode  = i_sample.clock_valid;
            n_shown       = 1'b1;
        end else if (r_shown) begin
            if (i_sample.clock_valid) begin
                // Restart the wait on mode entry or a backwards clock
                if (!r_clock_mode || clock_back) begin
                    n_stamp       = i_sample.time_usec;
                    n_idle_frames = '0;
                    n_clock_mode  = 1'b1;
                end else if (timed_out) begin
                    n_shown = 1'b0;
                end
            end else begin
                if (r_clock_mode) begin
                    n_idle_frames = '0;
                    n_clock_mode  = 1'b0;
                end else begin
                    n_idle_frames = frames_inc;
                    if (frames_inc >= i_cfg.fallback_frames) begin
                        n_shown = 1'b0;
                    end
                end
            end
        end else begin
            // Hidden and idle: hold the timer state and stay hidden
            n_shown = 1'b0;
        end
    end

    // Commit state when the sample moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first   <= 1'b0;
            r_anchor_x     <= '0;
            r_anchor_y     <= '0;
            r_prev_pressed <= 1'b0;
            r_stamp        <= '0;
            r_idle_frames  <= '0;
            r_clock_mode   <= 1'b0;
            r_shown        <= 1'b0;
        end else if (i_ctl.valid && i_ctl.advance) begin
            r_seen_first   <= n_seen_first;
            r_anchor_x     <= n_anchor_x;
            r_anchor_y     <= n_anchor_y;
            r_prev_pressed <= n_prev_pressed;
            r_stamp        <= n_stamp;
            r_idle_frames  <= n_idle_frames;
            r_clock_mode   <= n_clock_mode;
            r_shown        <= n_shown;
        end
    end

    assign o_result.cursor_x    = i_sample.pos_x;
    assign o_result.cursor_y    = i_sample.pos_y;
    assign o_result.show_cursor = n_shown;

endmodule

`default_nettype wire

// ----- src/cih_out_reg.sv -----
// ----------------------------------------------------------------------------
// cih_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cih_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire cih_pkg::t_result i_data,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output cih_pkg::t_result      o_data,
    output logic                  o_free
);
    import cih_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Room for a new result when empty or when the held one transfers now
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/cursor_inactivity_hider_top.sv -----
// ----------------------------------------------------------------------------
// cursor_inactivity_hider_top
// Shows the pointer cursor on activity and hides it after an idle timeout.
//
//   Channel   Dir  Handshake         Payload
//   i_sample  in   valid/ready       pos_x, pos_y, initial_deflection,
//                                    is_pressed, clock_valid, time_usec
//   o_result  out  valid/ready       cursor_x, cursor_y, show_cursor
//   i_cfg_*   in   write enable      index (2 bits), data (32 bits)
//
// One sample per cycle sustained while the result side is not stalled; a sample
// transfer passes the sample register, one update pass and the result register.
// State updates in the single update pass, so each sample sees the last.
// Reset is synchronous; configuration returns to 8 / 2000000 / 120.
// A stalled result holds in the result register; the sample register keeps
// accepting while the result register has room or is draining.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_inactivity_hider_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    cih_sample_if.sink                       i_sample,
    cih_result_if.source                     o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [cih_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cih_pkg::CFG_W-1:0]   i_cfg_data
);
    import cih_pkg::*;

    t_cfg       r_cfg;
    t_stage_ctl stage_ctl;
    t_sample    stage_sample;
    t_result    stage_result;
    logic       stage_valid;
    logic       out_free;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_threshold <= THRESHOLD_RST;
            r_cfg.timeout_usec     <= TIMEOUT_RST;
            r_cfg.fallback_frames  <= FALLBACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_THRESHOLD: r_cfg.motion_threshold <= i_cfg_data[POS_W-1:0];
                CFG_IDX_TIMEOUT:   r_cfg.timeout_usec     <= i_cfg_data[TOUT_W-1:0];
                CFG_IDX_FALLBACK:  r_cfg.fallback_frames  <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the held sample whenever the result register has room
    assign stage_ctl.valid   = stage_valid;
    assign stage_ctl.advance = stage_valid && out_free;

    cih_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_sample.valid),
        .i_data    (i_sample.data),
        .o_ready   (i_sample.ready),
        .i_advance (stage_ctl.advance),
        .o_valid   (stage_valid),
        .o_data    (stage_sample)
    );

    cih_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (stage_ctl),
        .i_sample (stage_sample),
        .i_cfg    (r_cfg),
        .o_result (stage_result)
    );

    cih_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_ctl.advance),
        .i_data  (stage_result),
        .i_ready (o_result.ready),
        .o_valid (o_result.valid),
        .o_data  (o_result.data),
        .o_free  (out_free)
    );

endmodule

`default_nettype wire

// ----- sim/cursor_inactivity_hider_top_tb.sv -----
// ----------------------------------------------------------------------------
// cursor_inactivity_hider_top_tb
// Self-checking bench for the cursor inactivity hider. A behavioral predictor
// tracks anchor, press edge, time stamp, idle frames and visibility for every
// sample transfer. A checker compares each result transfer field by field
// against the oldest prediction. Directed frames cover the register extremes
// and the special cases. A clock-less idle run counts frames past the hide
// point. Random phases then mix motion, presses, mode switches and clock
// jumps under random stalls on both channels, except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cursor_inactivity_hider_top_tb;

    import cih_pkg::*;

    localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 2'd3;   // unmapped, writes are dropped
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned IDLE_FRAMES    = 160;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    cih_sample_if sample_if ();
    cih_result_if result_if ();

    cursor_inactivity_hider_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Register shadows, as the block should hold them
    logic [POS_W-1:0]   thr_cfg;
    logic [TOUT_W-1:0]  tout_cfg;
    logic [FRAME_W-1:0] fb_cfg;

    // Predicted cursor state
    logic               have_anchor;
    logic [POS_W-1:0]   anc_x;
    logic [POS_W-1:0]   anc_y;
    logic               was_pressed;
    logic [TIME_W-1:0]  stamp_us;
    logic [FRAME_W-1:0] idle_cnt;
    logic               clk_mode;
    logic               visible;

    // Random pointer generator state
    logic [TIME_W-1:0] gen_time;
    logic              gen_clk;
    logic              gen_pressed;

    t_result     expected_cursor_q[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    logic        gaps_on = 1'b0;

    // Advance the predicted state by one sample and return the cursor it yields
    function automatic t_result predict_cursor(input t_sample s);
        t_result r;
        logic hit;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        dx = (s.pos_x >= anc_x) ? s.pos_x - anc_x : anc_x - s.pos_x;
        dy = (s.pos_y >= anc_y) ? s.pos_y - anc_y : anc_y - s.pos_y;
        if (!have_anchor) begin
            have_anchor = 1'b1;
            anc_x = s.pos_x;
            anc_y = s.pos_y;
            hit = s.initial_deflection | s.is_pressed;
        end else begin
            hit = (dx >= thr_cfg) || (dy >= thr_cfg) || (s.is_pressed && !was_pressed);
        end
        was_pressed = s.is_pressed;

        if (hit) begin
            anc_x = s.pos_x;
            anc_y = s.pos_y;
            stamp_us = s.time_usec;
            idle_cnt = '0;
            clk_mode = s.clock_valid;
            visible = 1'b1;
        end else if (visible) begin
            if (s.clock_valid) begin
                // Restart the wait on entering clock mode or on a clock that ran back
                if (!clk_mode || s.time_usec < stamp_us) begin
                    stamp_us = s.time_usec;
                    idle_cnt = '0;
                    clk_mode = 1'b1;
                end else if (s.time_usec - stamp_us >= {32'd0, tout_cfg}) begin
                    visible = 1'b0;
                end
            end else if (clk_mode) begin
                idle_cnt = '0;
                clk_mode = 1'b0;
            end else begin
                if (idle_cnt != FRAME_MAX)
                    idle_cnt = idle_cnt + 1'b1;
                if (idle_cnt >= fb_cfg)
                    visible = 1'b0;
            end
        end

        r.cursor_x = s.pos_x;
        r.cursor_y = s.pos_y;
        r.show_cursor = visible;
        return r;
    endfunction

    function automatic t_sample mk_sample(input int unsigned x, input int unsigned y,
                                          input logic defl, input logic prs,
                                          input logic clk_ok, input logic [TIME_W-1:0] t);
        t_sample s;
        s.pos_x = x[POS_W-1:0];
        s.pos_y = y[POS_W-1:0];
        s.initial_deflection = defl;
        s.is_pressed = prs;
        s.clock_valid = clk_ok;
        s.time_usec = t;
        return s;
    endfunction

    // Position on one axis: near the anchor, one threshold away, or anywhere
    function automatic logic [POS_W-1:0] pick_axis(input logic [POS_W-1:0] anchor,
                                                   input int unsigned sel);
        int v;
        int d;
        int unsigned span;
        span = (thr_cfg == 0) ? 0 : thr_cfg - 1;
        if (sel < 10) begin
            v = $urandom_range(0, 65535);
        end else if (sel < 18) begin
            v = anchor + thr_cfg;
            if (v > 65535)
                v = anchor - thr_cfg;
        end else begin
            d = $urandom_range(0, span);
            v = $urandom_range(0, 1) ? anchor + d : anchor - d;
        end
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[POS_W-1:0];
    endfunction

    function automatic t_sample next_random_sample();
        t_sample s;
        int unsigned r;
        if ($urandom_range(0, 19) == 0)
            gen_clk = ~gen_clk;
        if ($urandom_range(0, 7) == 0)
            gen_pressed = ~gen_pressed;
        r = $urandom_range(0, 29);
        if (r == 0)
            gen_time = gen_time - $urandom_range(1, 5000);
        else if (r == 1)
            gen_time = {$urandom, $urandom};
        else
            gen_time = gen_time + $urandom_range(0, (tout_cfg >> 2) + 2);
        s.pos_x = pick_axis(anc_x, $urandom_range(0, 99));
        s.pos_y = pick_axis(anc_y, $urandom_range(0, 99));
        s.initial_deflection = 1'($urandom_range(0, 1));
        s.is_pressed = gen_pressed;
        s.clock_valid = gen_clk;
        // Without a clock the time field is junk
        s.time_usec = gen_clk ? gen_time : {$urandom, $urandom};
        return s;
    endfunction

    // Offer one sample, hold it until the transfer, then record its prediction
    task automatic send_sample(input t_sample s);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.data <= s;
        @(posedge i_clk);
        while (!sample_if.ready)
            @(posedge i_clk);
        expected_cursor_q.push_back(predict_cursor(s));
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle_block();
        sample_if.valid <= 1'b0;
        while (expected_cursor_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_IDX_THRESHOLD: thr_cfg = val[POS_W-1:0];
            CFG_IDX_TIMEOUT:   tout_cfg = val[TOUT_W-1:0];
            CFG_IDX_FALLBACK:  fb_cfg = val[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] tout,
                              input logic [CFG_W-1:0] fb);
        settle_block();
        write_reg(CFG_IDX_THRESHOLD, thr);
        write_reg(CFG_IDX_TIMEOUT, tout);
        write_reg(CFG_IDX_FALLBACK, fb);
        write_reg(CFG_IDX_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Reset values: first-sample anchor, threshold edge, timeout, press edge,
    // clock running back, both mode switches, position extremes
    task automatic test_reset_defaults();
        send_sample(mk_sample(0, 0, 1'b0, 1'b0, 1'b1, 64'd0));
        send_sample(mk_sample(7, 7, 1'b0, 1'b0, 1'b1, 64'd10));
        send_sample(mk_sample(8, 0, 1'b0, 1'b0, 1'b1, 64'd20));
        send_sample(mk_sample(8, 0, 1'b0, 1'b0, 1'b1, 64'd2000019));
        send_sample(mk_sample(8, 0, 1'b0, 1'b0, 1'b1, 64'd2000020));
        send_sample(mk_sample(8, 0, 1'b0, 1'b1, 1'b1, 64'd2000030));
        send_sample(mk_sample(8, 0, 1'b0, 1'b1, 1'b1, 64'd5));
        send_sample(mk_sample(8, 0, 1'b0, 1'b0, 1'b0, 64'd6));
        send_sample(mk_sample(8, 0, 1'b0, 1'b0, 1'b1, 64'd100));
        send_sample(mk_sample(65535, 65535, 1'b1, 1'b0, 1'b0, TIME_MAX));
        send_sample(mk_sample(65535, 65528, 1'b0, 1'b0, 1'b0, TIME_MAX));
    endtask

    // Widest threshold, shortest timeout and frame count, time at the top
    task automatic test_register_extremes();
        set_config(32'd65535, 32'd1, 32'd1);
        send_sample(mk_sample(0, 0, 1'b0, 1'b0, 1'b0, 64'd0));
        send_sample(mk_sample(0, 1, 1'b0, 1'b0, 1'b0, 64'd0));
        send_sample(mk_sample(0, 0, 1'b0, 1'b1, 1'b0, 64'd0));
        send_sample(mk_sample(0, 0, 1'b0, 1'b1, 1'b1, TIME_MAX - 1));
        send_sample(mk_sample(0, 0, 1'b0, 1'b0, 1'b1, TIME_MAX));
    endtask

    // Zero timeout and zero frame count hide at once; zero threshold always fires
    task automatic test_zero_registers();
        set_config(32'd1, 32'd0, 32'd0);
        send_sample(mk_sample(5, 5, 1'b0, 1'b0, 1'b1, 64'd50));
        send_sample(mk_sample(5, 5, 1'b0, 1'b0, 1'b1, 64'd50));
        send_sample(mk_sample(5, 5, 1'b0, 1'b1, 1'b0, 64'd0));
        send_sample(mk_sample(5, 5, 1'b0, 1'b1, 1'b0, 64'd0));
        set_config(32'd0, 32'd0, 32'd0);
        send_sample(mk_sample(5, 5, 1'b0, 1'b0, 1'b1, 64'd60));
        send_sample(mk_sample(5, 5, 1'b0, 1'b0, 1'b1, 64'd60));
    endtask

    // Count clock-less idle frames past the hide point
    task automatic test_frame_count_limit();
        set_config(32'd65535, 32'd1000, 32'd150);
        gaps_on = 1'b0;
        send_sample(mk_sample(100, 100, 1'b0, 1'b1, 1'b0, 64'd0));
        repeat (IDLE_FRAMES)
            send_sample(mk_sample(100, 100, 1'b0, 1'b0, 1'b0, {$urandom, $urandom}));
    endtask

    task automatic test_random_pointer();
        gen_time = {$urandom, $urandom};
        gen_clk = 1'b1;
        gen_pressed = 1'b0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(32'd4, 32'd300, 32'd6);
                1: set_config($urandom_range(1, 64), $urandom_range(1, 5000),
                              $urandom_range(1, 40));
                2: set_config(32'd65535, 32'hFFFF_FFFF, 32'd65535);
                3: set_config(32'd1, 32'd1, 32'd1);
                4: set_config($urandom_range(1, 32), $urandom_range(1, 800),
                              $urandom_range(1, 12));
                default: set_config({16'd0, THRESHOLD_RST}, TIMEOUT_RST, {16'd0, FALLBACK_RST});
            endcase
            // Run the last phase without idling on either side
            gaps_on = (ph != 5);
            repeat (PHASE_ITEMS)
                send_sample(next_random_sample());
        end
    endtask

    task automatic note_mismatch(input string field, input longint unsigned exp_v,
                                 input longint unsigned act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0h, actual %0h", field, exp_v, act_v);
    endtask

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_cursor_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result transfer with nothing expected: %h", result_if.data);
            end else begin
                exp_r = expected_cursor_q.pop_front();
                if (result_if.data.cursor_x !== exp_r.cursor_x)
                    note_mismatch("cursor_x", exp_r.cursor_x, result_if.data.cursor_x);
                if (result_if.data.cursor_y !== exp_r.cursor_y)
                    note_mismatch("cursor_y", exp_r.cursor_y, result_if.data.cursor_y);
                if (result_if.data.show_cursor !== exp_r.show_cursor)
                    note_mismatch("show_cursor", exp_r.show_cursor, result_if.data.show_cursor);
            end
        end
    end

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_if.ready <= (stall_left == 1);
        end else if (gaps_on && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 17);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_if.valid && sample_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDX_THRESHOLD;
        i_cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.data = '0;

        thr_cfg = THRESHOLD_RST;
        tout_cfg = TIMEOUT_RST;
        fb_cfg = FALLBACK_RST;
        have_anchor = 1'b0;
        anc_x = '0;
        anc_y = '0;
        was_pressed = 1'b0;
        stamp_us = '0;
        idle_cnt = '0;
        clk_mode = 1'b0;
        visible = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_zero_registers();
        test_frame_count_limit();
        test_random_pointer();

        settle_block();
        if (mismatch_count == 0 && expected_cursor_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
